>>> hdl/sha256_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the SHA-256 message hasher.
// Depends on nothing; used by every module in this folder.
package sha256_pkg;

	localparam int unsigned WORD_W   = 32;
	localparam int unsigned BLOCK_WORDS = 16;
	localparam int unsigned ROUNDS   = 64;

	localparam logic [7:0] PAD_MARK  = 8'h80;
	localparam logic [5:0] LEN_POS   = 6'd56;
	localparam logic [5:0] FILL_LAST = 6'd63;
	localparam logic [5:0] ROUND_LAST = 6'd63;
	localparam logic [2:0] WORD_LAST = 3'd7;

	localparam logic OP_ABSORB = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	// Initial hash value, word 0 in the lowest slot.
	localparam logic [7:0][31:0] H_INIT = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_FOLD,
		ST_EMIT
	} sha256_state_t;

	// Commands from the sequencer to the compression core.
	typedef struct packed {
		logic init;    // reload the initial hash value
		logic start;   // copy hash words into the working variables
		logic round;   // run one compression round
		logic fold;    // add working variables into the hash words
		logic rotate;  // move the next digest word to the front
	} sha256_core_cmd_t;

endpackage

>>> hdl/sha256_wsched.sv
`timescale 1ns / 1ps
// Block buffer and message schedule: a 16-word window that takes bytes
// while filling and slides one word per round. Depends on sha256_pkg.
module sha256_wsched (
	input  logic        clk,
	input  logic        push_en,
	input  logic [7:0]  push_byte,
	input  logic        shift_en,
	output logic [31:0] w_t
);

	localparam int unsigned WIN_W = sha256_pkg::BLOCK_WORDS * sha256_pkg::WORD_W;

	// Oldest word in slot 15.
	logic [15:0][31:0] win_q;
	logic [31:0]       w_new;

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

	assign w_t   = win_q[15];
	assign w_new = win_q[15] + small_sigma0(win_q[14]) + win_q[6] + small_sigma1(win_q[1]);

	always_ff @(posedge clk) begin
		if (push_en) begin
			win_q <= WIN_W'({win_q, push_byte});
		end else if (shift_en) begin
			win_q <= {win_q[14:0], w_new};
		end
	end

endmodule

>>> hdl/sha256_core.sv
`timescale 1ns / 1ps
// Compression core: hash words, working variables and the shared round unit.
// Depends on sha256_pkg.
module sha256_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sha256_pkg::sha256_core_cmd_t  cmd,
	input  logic [5:0]                    round_idx,
	input  logic [31:0]                   w_t,
	output logic [31:0]                   digest_word
);

	logic [7:0][31:0] hash_q;
	logic [7:0][31:0] work_q;   // a in slot 0 through h in slot 7
	logic [31:0]      t1, t2;

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	assign t1 = work_q[7] + big_sigma1(work_q[4])
		+ ((work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]))
		+ sha256_pkg::ROUND_K[round_idx] + w_t;
	assign t2 = big_sigma0(work_q[0])
		+ ((work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]));

	assign digest_word = hash_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= sha256_pkg::H_INIT;
		end else if (cmd.init) begin
			hash_q <= sha256_pkg::H_INIT;
		end else if (cmd.fold) begin
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= hash_q[i] + work_q[i];
			end
		end else if (cmd.rotate) begin
			hash_q <= {hash_q[0], hash_q[7:1]};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			work_q <= hash_q;
		end else if (cmd.round) begin
			work_q <= {work_q[6:4], work_q[3] + t1, work_q[2:0], t1 + t2};
		end
	end

endmodule

>>> hdl/sha256_message_hasher.sv
`timescale 1ns / 1ps
// SHA-256 message hasher, top level.
// Input channel (item_valid / item_stall, op, data_byte): an absorb item
// (op 0) adds one message byte; a finish item (op 1) pads the message and
// starts the digest. An item is taken when item_valid is high and
// item_stall is low; item_stall is high whenever the block is busy.
// Output channel (digest_valid / digest_stall): a finish yields eight items,
// digest_word in big-endian word order with word_index 0..7 and last_word on
// the eighth. While digest_stall is high the current word holds.
// An absorb that fills the 64-byte block is followed by 64 rounds of the single
// round unit and one fold before the next item is taken.
// A finish feeds its padding bytes through the byte buffer one per cycle,
// then compresses; when 56 or more bytes are held at the finish, the length
// spills into a second block that is padded and compressed as well.
// The round unit is the rate limit: no item is taken during compression.
// Reset loads the initial hash value and empties the byte buffer and the
// length count; after the eighth word is taken the same happens.
// Depends on sha256_pkg, sha256_wsched and sha256_core.
module sha256_message_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        op,
	input  logic [7:0]  data_byte,
	output logic        digest_valid,
	input  logic        digest_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	sha256_pkg::sha256_state_t    state_q, state_d;
	sha256_pkg::sha256_core_cmd_t core_cmd;

	logic [5:0]  fill_q;       // bytes held in the block buffer
	logic [63:0] msg_q;        // message bytes absorbed
	logic [63:0] len_q;        // bit length, shifted out high byte first
	logic [5:0]  round_q;
	logic [2:0]  idx_q;
	logic        finishing_q;  // a finish is being padded or compressed
	logic        len_mode_q;   // length bytes are going into the buffer

	logic        push_en;
	logic [7:0]  push_byte;
	logic        shift_en;
	logic        absorb;
	logic        capture_len;
	logic        len_shift;
	logic        len_set;
	logic        round_en;
	logic        emit_take;
	logic        emit_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha256_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		core_cmd    = '0;
		item_stall  = 1'b1;
		digest_valid = 1'b0;
		push_en     = 1'b0;
		push_byte   = 8'd0;
		shift_en    = 1'b0;
		absorb      = 1'b0;
		capture_len = 1'b0;
		len_shift   = 1'b0;
		len_set     = 1'b0;
		round_en    = 1'b0;
		emit_take   = 1'b0;
		emit_done   = 1'b0;
		unique case (state_q)
			sha256_pkg::ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					push_en = 1'b1;
					if (op == sha256_pkg::OP_FINISH) begin
						// The pad mark goes in with the finish item itself.
						push_byte   = sha256_pkg::PAD_MARK;
						capture_len = 1'b1;
						state_d     = sha256_pkg::ST_PAD;
					end else begin
						push_byte = data_byte;
						absorb    = 1'b1;
					end
					if (fill_q == sha256_pkg::FILL_LAST) begin
						core_cmd.start = 1'b1;
						state_d        = sha256_pkg::ST_ROUND;
					end
				end
			end
			sha256_pkg::ST_PAD: begin
				push_en = 1'b1;
				if (len_mode_q) begin
					push_byte = len_q[63:56];
					len_shift = 1'b1;
				end else if (fill_q == sha256_pkg::LEN_POS) begin
					push_byte = len_q[63:56];
					len_shift = 1'b1;
					len_set   = 1'b1;
				end
				if (fill_q == sha256_pkg::FILL_LAST) begin
					core_cmd.start = 1'b1;
					state_d        = sha256_pkg::ST_ROUND;
				end
			end
			sha256_pkg::ST_ROUND: begin
				core_cmd.round = 1'b1;
				shift_en       = 1'b1;
				round_en       = 1'b1;
				if (round_q == sha256_pkg::ROUND_LAST) begin
					state_d = sha256_pkg::ST_FOLD;
				end
			end
			sha256_pkg::ST_FOLD: begin
				core_cmd.fold = 1'b1;
				if (!finishing_q) begin
					state_d = sha256_pkg::ST_IDLE;
				end else if (len_mode_q) begin
					state_d = sha256_pkg::ST_EMIT;
				end else begin
					state_d = sha256_pkg::ST_PAD;
				end
			end
			sha256_pkg::ST_EMIT: begin
				digest_valid = 1'b1;
				if (!digest_stall) begin
					emit_take = 1'b1;
					if (idx_q == sha256_pkg::WORD_LAST) begin
						// Last word taken: start over for the next message.
						core_cmd.init = 1'b1;
						emit_done     = 1'b1;
						state_d       = sha256_pkg::ST_IDLE;
					end else begin
						core_cmd.rotate = 1'b1;
					end
				end
			end
			default: begin
				state_d = sha256_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			msg_q       <= '0;
			len_q       <= '0;
			round_q     <= '0;
			idx_q       <= '0;
			finishing_q <= 1'b0;
			len_mode_q  <= 1'b0;
		end else begin
			if (push_en) begin
				fill_q <= fill_q + 6'd1;
			end
			if (capture_len) begin
				len_q <= {msg_q[60:0], 3'b000};
				msg_q <= '0;
			end else begin
				if (absorb) begin
					msg_q <= msg_q + 64'd1;
				end
				if (len_shift) begin
					len_q <= {len_q[55:0], 8'd0};
				end
			end
			if (round_en) begin
				round_q <= round_q + 6'd1;
			end
			if (emit_take) begin
				idx_q <= idx_q + 3'd1;
			end
			if (capture_len) begin
				finishing_q <= 1'b1;
			end else if (emit_done) begin
				finishing_q <= 1'b0;
			end
			if (len_set) begin
				len_mode_q <= 1'b1;
			end else if (emit_done) begin
				len_mode_q <= 1'b0;
			end
		end
	end

	logic [31:0] w_t;

	sha256_wsched u_wsched (
		.clk       (clk),
		.push_en   (push_en),
		.push_byte (push_byte),
		.shift_en  (shift_en),
		.w_t       (w_t)
	);

	sha256_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (core_cmd),
		.round_idx   (round_q),
		.w_t         (w_t),
		.digest_word (digest_word)
	);

	assign word_index = idx_q;
	assign last_word  = (idx_q == sha256_pkg::WORD_LAST);

endmodule
